// ----- hw/rtl/lru_pinned_page_buffer_manager_defines.svh -----
// Assertion macros shared by the buffer manager RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef LRU_PINNED_PAGE_BUFFER_MANAGER_DEFINES_SVH
`define LRU_PINNED_PAGE_BUFFER_MANAGER_DEFINES_SVH

`define LPBM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("buffer manager check failed");

`define LPBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("buffer manager check failed");

`endif

// ----- hw/rtl/lpbm_pkg.sv -----
// Types and constants of the LRU pinned page buffer manager.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpbm_pkg;

  localparam int unsigned ACT_W  = 3;
  localparam int unsigned FILE_W = 8;
  localparam int unsigned PAGE_W = 24;
  localparam int unsigned SLOT_W = 6;

  typedef enum logic [ACT_W-1:0] {
    ACT_GET   = 3'd0,
    ACT_ALLOC = 3'd1,
    ACT_DIRTY = 3'd2,
    ACT_UNPIN = 3'd3,
    ACT_FORCE = 3'd4
  } action_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [FILE_W-1:0] file_id;
    logic [PAGE_W-1:0] page_num;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              fetch_valid;
    logic              writeback_valid;
    logic [FILE_W-1:0] writeback_file;
    logic [PAGE_W-1:0] writeback_page;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lpbm_slot_ram.sv -----
// Slot table memory: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lpbm_slot_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lru_pinned_page_buffer_manager.sv -----
// Top level of the LRU pinned page buffer manager.
// Depends on lpbm_pkg, lpbm_slot_ram and lru_pinned_page_buffer_manager_defines.svh.
//
//   channel   direction   handshake            payload
//   request   in          in_valid_i/in_stall_o     req_t
//   result    out         out_valid_o/out_stall_i   res_t
//
// After reset the slot table is initialized slot by slot; no request is taken
// meanwhile. A request takes a tag scan over the slots through the single read
// port, then relinking of the LRU list, plus a read of each slot stepped over in
// the LRU walk for a victim. One request is in work at a time; a finished
// result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module lru_pinned_page_buffer_manager
  import lpbm_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 64,
  parameter int unsigned PIN_BITS  = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output res_t      out_o
);

  localparam int unsigned AW = $clog2(NUM_SLOTS);
  localparam int unsigned LW = $clog2(NUM_SLOTS + 1);
  localparam logic [LW-1:0] NIL = LW'(NUM_SLOTS);
  localparam logic [AW-1:0] LAST = AW'(NUM_SLOTS - 1);

  typedef struct packed {
    logic                valid;
    logic                dirty;
    logic [PIN_BITS-1:0] pin;
    logic [LW-1:0]       prev;
    logic [LW-1:0]       next;
    logic [FILE_W-1:0]   file;
    logic [PAGE_W-1:0]   page;
  } entry_t;

  localparam int unsigned EW = $bits(entry_t);

  typedef enum logic [15:0] {
    S_INIT     = 16'h0001,
    S_IDLE     = 16'h0002,
    S_SCAN     = 16'h0004,
    S_DEC      = 16'h0008,
    S_FREE_CHK = 16'h0010,
    S_VIC_CHK  = 16'h0020,
    S_DET      = 16'h0040,
    S_DN_WR    = 16'h0080,
    S_DP_WR    = 16'h0100,
    S_ATT      = 16'h0200,
    S_AH_WR    = 16'h0400,
    S_FIN      = 16'h0800,
    S_OUT      = 16'h1000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] head_q, head_d, tail_q, tail_d, free_q, free_d;
  logic          out_valid_q, out_valid_d;
  res_t          out_q, out_d;
  req_t          req_q, req_d;
  res_t          res_q, res_d;
  entry_t        cur_q, cur_d;
  logic [AW-1:0] x_q, x_d;
  logic          hit_q, hit_d;
  logic          relink_q, relink_d;
  logic [AW-1:0] ra_q, rd_addr;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;
  logic [EW-1:0] rdata_raw;
  entry_t        rdata;

  assign rdata = entry_t'(rdata_raw);

  lpbm_slot_ram #(
    .DEPTH(NUM_SLOTS),
    .WIDTH(EW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_wa),
    .wdata_i(EW'(mem_wd)),
    .raddr_i(rd_addr),
    .rdata_o(rdata_raw)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    tail_d      = tail_q;
    free_d      = free_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    req_d       = req_q;
    res_d       = res_q;
    cur_d       = cur_q;
    x_d         = x_q;
    hit_d       = hit_q;
    relink_d    = relink_q;
    rd_addr     = ra_q;
    mem_we      = 1'b0;
    mem_wa      = x_q;
    mem_wd      = cur_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_INIT: begin
        mem_we      = 1'b1;
        mem_wa      = cnt_q;
        mem_wd      = '0;
        mem_wd.prev = NIL;
        mem_wd.next = LW'(cnt_q) + LW'(1);
        cnt_d       = cnt_q + AW'(1);
        if (cnt_q == LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        rd_addr = '0;
        if (in_valid_i) begin
          req_d   = in_i;
          res_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rdata.valid && rdata.file == req_q.file_id && rdata.page == req_q.page_num) begin
          hit_d   = 1'b1;
          x_d     = ra_q;
          cur_d   = rdata;
          state_d = S_DEC;
        end else if (ra_q == LAST) begin
          hit_d   = 1'b0;
          state_d = S_DEC;
        end else begin
          rd_addr = ra_q + AW'(1);
        end
      end
      S_DEC: begin
        relink_d = 1'b1;
        state_d  = S_OUT;
        if (hit_q) begin
          res_d.slot = SLOT_W'(x_q);
          res_d.hit  = 1'b1;
        end
        if (req_q.action == ACT_GET && hit_q) begin
          if (cur_q.pin != '1) begin
            cur_d.pin = cur_q.pin + PIN_BITS'(1);
          end
          state_d = S_DET;
        end else if (req_q.action == ACT_GET || req_q.action == ACT_ALLOC) begin
          cur_d.valid       = 1'b1;
          cur_d.dirty       = 1'b0;
          cur_d.pin         = PIN_BITS'(1);
          cur_d.file        = req_q.file_id;
          cur_d.page        = req_q.page_num;
          res_d.fetch_valid = 1'b1;
          if (hit_q) begin
            state_d = S_DET;
          end else if (free_q != NIL) begin
            x_d     = free_q[AW-1:0];
            rd_addr = free_q[AW-1:0];
            state_d = S_FREE_CHK;
          end else if (tail_q != NIL) begin
            x_d     = tail_q[AW-1:0];
            rd_addr = tail_q[AW-1:0];
            state_d = S_VIC_CHK;
          end else begin
            res_d        = '0;
            res_d.status = 1'b1;
          end
        end else if (req_q.action == ACT_DIRTY && hit_q) begin
          cur_d.dirty = 1'b1;
          state_d     = S_DET;
        end else if (req_q.action == ACT_UNPIN && hit_q) begin
          if (cur_q.pin != '0) begin
            cur_d.pin = cur_q.pin - PIN_BITS'(1);
          end
          relink_d = (cur_q.pin == PIN_BITS'(1)) || (cur_q.pin == '0);
          state_d  = relink_d ? S_DET : S_FIN;
        end else if (req_q.action == ACT_FORCE && hit_q) begin
          relink_d = 1'b0;
          if (cur_q.dirty) begin
            res_d.writeback_valid = 1'b1;
            res_d.writeback_file  = cur_q.file;
            res_d.writeback_page  = cur_q.page;
            cur_d.dirty           = 1'b0;
          end
          state_d = S_FIN;
        end else begin
          res_d = '0;
        end
      end
      S_FREE_CHK: begin
        free_d     = rdata.next;
        res_d.slot = SLOT_W'(x_q);
        state_d    = S_ATT;
      end
      S_VIC_CHK: begin
        if (rdata.pin == '0) begin
          cur_d.prev = rdata.prev;
          cur_d.next = rdata.next;
          res_d.slot = SLOT_W'(x_q);
          if (rdata.valid && rdata.dirty) begin
            res_d.writeback_valid = 1'b1;
            res_d.writeback_file  = rdata.file;
            res_d.writeback_page  = rdata.page;
          end
          state_d = S_DET;
        end else if (rdata.prev != NIL) begin
          x_d     = rdata.prev[AW-1:0];
          rd_addr = rdata.prev[AW-1:0];
        end else begin
          res_d        = '0;
          res_d.status = 1'b1;
          state_d      = S_OUT;
        end
      end
      S_DET: begin
        if (head_q == LW'(x_q)) begin
          head_d = cur_q.next;
        end
        if (tail_q == LW'(x_q)) begin
          tail_d = cur_q.prev;
        end
        if (cur_q.next != NIL) begin
          rd_addr = cur_q.next[AW-1:0];
          state_d = S_DN_WR;
        end else if (cur_q.prev != NIL) begin
          rd_addr = cur_q.prev[AW-1:0];
          state_d = S_DP_WR;
        end else begin
          state_d = S_ATT;
        end
      end
      S_DN_WR: begin
        mem_we      = 1'b1;
        mem_wa      = cur_q.next[AW-1:0];
        mem_wd      = rdata;
        mem_wd.prev = cur_q.prev;
        if (cur_q.prev != NIL) begin
          rd_addr = cur_q.prev[AW-1:0];
          state_d = S_DP_WR;
        end else begin
          state_d = S_ATT;
        end
      end
      S_DP_WR: begin
        mem_we      = 1'b1;
        mem_wa      = cur_q.prev[AW-1:0];
        mem_wd      = rdata;
        mem_wd.next = cur_q.next;
        state_d     = S_ATT;
      end
      S_ATT: begin
        if (head_q != NIL) begin
          rd_addr = head_q[AW-1:0];
          state_d = S_AH_WR;
        end else begin
          state_d = S_FIN;
        end
      end
      S_AH_WR: begin
        mem_we      = 1'b1;
        mem_wa      = head_q[AW-1:0];
        mem_wd      = rdata;
        mem_wd.prev = LW'(x_q);
        state_d     = S_FIN;
      end
      S_FIN: begin
        mem_we = 1'b1;
        mem_wa = x_q;
        mem_wd = cur_q;
        if (relink_q) begin
          mem_wd.next = head_q;
          mem_wd.prev = NIL;
          head_d      = LW'(x_q);
          if (tail_q == NIL) begin
            tail_d = LW'(x_q);
          end
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      head_q      <= NIL;
      tail_q      <= NIL;
      free_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    req_q    <= req_d;
    res_q    <= res_d;
    cur_q    <= cur_d;
    x_q      <= x_d;
    hit_q    <= hit_d;
    relink_q <= relink_d;
    ra_q     <= rd_addr;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`include "lru_pinned_page_buffer_manager_defines.svh"

  `LPBM_ASSERT_NEXT(a_accept_scans, in_valid_i && !in_stall_o, state_q == S_SCAN)
  `LPBM_ASSERT_IMPL(a_list_ends, state_q != S_INIT, (head_q == NIL) == (tail_q == NIL))
  `LPBM_ASSERT_IMPL(a_nobuf_clean, out_valid_o && out_o.status,
                    !out_o.fetch_valid && !out_o.hit && !out_o.writeback_valid)
  `LPBM_ASSERT_IMPL(a_wb_cause, out_valid_o && out_o.writeback_valid,
                    out_o.hit || out_o.fetch_valid)

endmodule

`default_nettype wire

// ----- tb/tb_lru_pinned_page_buffer_manager.sv -----
// Self-checking testbench of the LRU pinned page buffer manager.
// Predicts every result with a slot and LRU list model of its own and compares the whole result.
// Depends on lpbm_pkg and lru_pinned_page_buffer_manager.
`timescale 1ns / 1ps

module tb_lru_pinned_page_buffer_manager;
  import lpbm_pkg::*;

  localparam int NSLOT = 64;
  localparam int NIL = NSLOT;
  localparam int PIN_MAX = 255;
  localparam int WATCH_LIMIT = 40000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  req_t in_req;
  res_t out_res;

  lru_pinned_page_buffer_manager dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_i(in_req),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_o(out_res)
  );

  logic [FILE_W-1:0] m_file [NSLOT];
  logic [PAGE_W-1:0] m_page [NSLOT];
  bit m_valid [NSLOT];
  bit m_dirty [NSLOT];
  int m_pins [NSLOT];
  int m_prev [NSLOT];
  int m_next [NSLOT];
  int m_head, m_tail, m_free;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int mismatches = 0;
  bit stimulus_done = 1'b0;
  int hold_off = 0;
  int idle_cycles = 0;
  logic in_stall_q;
  logic out_valid_q_acc;

  // Key pools: a small working set so that hits, evictions and pinning all occur.
  logic [FILE_W-1:0] pool_file [96];
  logic [PAGE_W-1:0] pool_page [96];

  function automatic void unlink(int s);
    int n, p;
    n = m_next[s];
    p = m_prev[s];
    if (m_head == s) m_head = n;
    if (m_tail == s) m_tail = p;
    if (n < NSLOT) m_prev[n] = p;
    if (p < NSLOT) m_next[p] = n;
    m_prev[s] = NIL;
    m_next[s] = NIL;
  endfunction

  function automatic void link_head(int s);
    m_next[s] = m_head;
    m_prev[s] = NIL;
    if (m_head < NSLOT) m_prev[m_head] = s;
    m_head = s;
    if (m_tail >= NSLOT) m_tail = s;
  endfunction

  function automatic void make_recent(int s);
    unlink(s);
    link_head(s);
  endfunction

  function automatic res_t predict_result(req_t r);
    res_t o;
    int s, v, steps;
    bit hit;
    o = '0;
    s = NIL;
    for (int i = 0; i < NSLOT; i++)
      if (s == NIL && m_valid[i] && m_file[i] == r.file_id && m_page[i] == r.page_num) s = i;
    hit = s < NSLOT;
    if (r.action == ACT_GET && hit) begin
      if (m_pins[s] < PIN_MAX) m_pins[s]++;
      make_recent(s);
      o.slot = SLOT_W'(s);
      o.hit = 1'b1;
    end else if (r.action == ACT_GET || r.action == ACT_ALLOC) begin
      if (r.action == ACT_ALLOC && hit) begin
        unlink(s);
        m_valid[s] = 1'b0;
        m_dirty[s] = 1'b0;
        m_pins[s] = 0;
        m_next[s] = m_free;
        m_free = s;
      end
      if (m_free < NSLOT) begin
        v = m_free;
        m_free = m_next[v];
      end else begin
        steps = 0;
        v = m_tail;
        while (v < NSLOT && steps < NSLOT && m_pins[v] != 0) begin
          v = m_prev[v];
          steps++;
        end
        if (v >= NSLOT || m_pins[v] != 0) begin
          o.status = 1'b1;
          return o;
        end
        if (m_valid[v] && m_dirty[v]) begin
          o.writeback_valid = 1'b1;
          o.writeback_file = m_file[v];
          o.writeback_page = m_page[v];
        end
        unlink(v);
      end
      link_head(v);
      m_file[v] = r.file_id;
      m_page[v] = r.page_num;
      m_valid[v] = 1'b1;
      m_dirty[v] = 1'b0;
      m_pins[v] = 1;
      o.slot = SLOT_W'(v);
      o.hit = hit;
      o.fetch_valid = 1'b1;
    end else if (r.action == ACT_DIRTY && hit) begin
      m_dirty[s] = 1'b1;
      make_recent(s);
      o.slot = SLOT_W'(s);
      o.hit = 1'b1;
    end else if (r.action == ACT_UNPIN && hit) begin
      if (m_pins[s] > 0) m_pins[s]--;
      if (m_pins[s] == 0) make_recent(s);
      o.slot = SLOT_W'(s);
      o.hit = 1'b1;
    end else if (r.action == ACT_FORCE && hit) begin
      if (m_dirty[s]) begin
        o.writeback_valid = 1'b1;
        o.writeback_file = m_file[s];
        o.writeback_page = m_page[s];
        m_dirty[s] = 1'b0;
      end
      o.slot = SLOT_W'(s);
      o.hit = 1'b1;
    end
    return o;
  endfunction

  function automatic req_t make_req(logic [ACT_W-1:0] act, logic [FILE_W-1:0] f,
                                    logic [PAGE_W-1:0] p);
    req_t r;
    r.action = act;
    r.file_id = f;
    r.page_num = p;
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      m_file[i] = '0;
      m_page[i] = '0;
      m_valid[i] = 1'b0;
      m_dirty[i] = 1'b0;
      m_pins[i] = 0;
      m_prev[i] = NIL;
      m_next[i] = i + 1;
    end
    m_head = NIL;
    m_tail = NIL;
    m_free = 0;
    for (int i = 0; i < 96; i++) begin
      if (i == 0) begin
        pool_file[i] = 8'h00;
        pool_page[i] = 24'h0;
      end else if (i == 1) begin
        pool_file[i] = 8'hFF;
        pool_page[i] = 24'hFFFFFF;
      end else begin
        pool_file[i] = FILE_W'($urandom_range(0, 255));
        pool_page[i] = PAGE_W'($urandom);
      end
    end
    rst_n = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  initial begin
    int act, k, burst;
    // Directed: extremes, every action, misses on hit-only actions, unknown actions.
    pending_reqs.push_back(make_req(ACT_UNPIN, 8'h00, 24'h0));
    pending_reqs.push_back(make_req(ACT_FORCE, 8'hFF, 24'hFFFFFF));
    pending_reqs.push_back(make_req(ACT_DIRTY, 8'h12, 24'h345678));
    pending_reqs.push_back(make_req(ACT_GET, 8'h00, 24'h0));
    pending_reqs.push_back(make_req(ACT_GET, 8'hFF, 24'hFFFFFF));
    pending_reqs.push_back(make_req(ACT_GET, 8'h00, 24'h0));
    pending_reqs.push_back(make_req(ACT_DIRTY, 8'hFF, 24'hFFFFFF));
    pending_reqs.push_back(make_req(ACT_FORCE, 8'hFF, 24'hFFFFFF));
    pending_reqs.push_back(make_req(ACT_FORCE, 8'hFF, 24'hFFFFFF));
    pending_reqs.push_back(make_req(ACT_UNPIN, 8'h00, 24'h0));
    pending_reqs.push_back(make_req(ACT_UNPIN, 8'h00, 24'h0));
    pending_reqs.push_back(make_req(ACT_UNPIN, 8'h00, 24'h0));
    pending_reqs.push_back(make_req(ACT_DIRTY, 8'hFF, 24'hFFFFFF));
    pending_reqs.push_back(make_req(ACT_ALLOC, 8'hFF, 24'hFFFFFF));
    pending_reqs.push_back(make_req(ACT_ALLOC, 8'hA5, 24'h5A5A5A));
    pending_reqs.push_back(make_req(3'd5, 8'hFF, 24'hFFFFFF));
    pending_reqs.push_back(make_req(3'd7, 8'h00, 24'h0));
    // Pin every slot, then ask for one more page: no buffer.
    for (int i = 0; i < 64; i++)
      pending_reqs.push_back(make_req(ACT_GET, 8'h40, 24'(i + 1)));
    pending_reqs.push_back(make_req(ACT_GET, 8'h41, 24'h1));
    wait_drained();
    // Long receiver hold-off while the sender keeps offering items.
    hold_off = 300;
    for (int i = 0; i < 20; i++)
      pending_reqs.push_back(make_req(ACT_UNPIN, 8'h40, 24'(i + 1)));
    wait_drained();
    for (int n = 0; n < 1850; n++) begin
      k = $urandom_range(0, 95);
      burst = $urandom_range(0, 99);
      if (burst < 50) act = $urandom_range(0, 1);
      else if (burst < 95) act = $urandom_range(2, 4);
      else act = $urandom_range(5, 7);
      if ($urandom_range(0, 9) == 0)
        pending_reqs.push_back(make_req(act[2:0], FILE_W'($urandom_range(0, 255)),
                                        PAGE_W'($urandom)));
      else
        pending_reqs.push_back(make_req(act[2:0], pool_file[k], pool_page[k]));
      if (burst > 60 && act == ACT_GET)
        pending_reqs.push_back(make_req(ACT_UNPIN, pool_file[k], pool_page[k]));
      if (n == 900) wait_drained();
      while (pending_reqs.size() > 8) @(posedge clk);
    end
    stimulus_done = 1'b1;
  end

  int send_gap = 0;
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_req <= '0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall_q) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_req <= pending_reqs.pop_front();
        in_valid <= 1'b1;
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Acceptance of the last edge, as seen at the following falling edge.
  always @(posedge clk) begin
    in_stall_q <= in_stall;
    if (rst_n && in_valid && !in_stall)
      expected_results.push_back(predict_result(in_req));
  end

  int recv_gap = 0;
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b1;
      recv_gap <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid_q_acc)
        recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    res_t exp_res;
    out_valid_q_acc <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected transfer: %p", out_res);
      end else begin
        exp_res = expected_results.pop_front();
        if (out_res !== exp_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %p, got %p", exp_res, out_res);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || hold_off > 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge rst_n);
    wait (stimulus_done && pending_reqs.size() == 0 && !in_valid &&
          expected_results.size() == 0 || idle_cycles >= WATCH_LIMIT);
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("** lru_pinned_page_buffer_manager: FAILED **");
    end else begin
      repeat (200) @(posedge clk);
      if (mismatches == 0 && expected_results.size() == 0 && !out_valid)
        $display("** lru_pinned_page_buffer_manager: PASSED **");
      else
        $display("** lru_pinned_page_buffer_manager: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/lpbm_pkg.sv
hw/rtl/lpbm_slot_ram.sv
hw/rtl/lru_pinned_page_buffer_manager.sv
tb/tb_lru_pinned_page_buffer_manager.sv
